[src/csfv_pkg.sv]
// Shared types, pipeline depths and the CORDIC arctangent table for the
// cube-sphere face vertex generator. No dependencies.
`timescale 1ns / 1ps
package csfv_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
  localparam int CORDIC_W     = 34;
  localparam int SQRT_STEPS   = 19;
  localparam int DIV_STEPS    = 17;

  // pi/4 in Q2.30
  localparam logic [29:0] ATAN0 = 30'd843314856;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sh0_4000_0000;

  // Configuration register indexes
  localparam logic REG_LEVEL  = 1'b0;
  localparam logic REG_RADIUS = 1'b1;

  typedef struct packed {
    logic       valid;
    logic       bad;
    logic       kill;
    logic [2:0] neg;
  } csfv_side_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      24: v = 30'd63;
      25: v = 30'd31;
      26: v = 30'd15;
      27: v = 30'd7;
      28: v = 30'd3;
      29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Magnitude of a product after a right shift by 15 (truncation toward zero).
  function automatic logic [17:0] abs_shr15(input logic signed [37:0] p);
    logic [37:0] a;
    a = p[37] ? 38'(-p) : 38'(p);
    return a[32:15];
  endfunction

endpackage

[src/csfv_in_if.sv]
// Input channel of the vertex generator: valid/ready plus one grid index pair.
// Depends on nothing.
`timescale 1ns / 1ps
interface csfv_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] row_index;
  logic [8:0] column_index;

  modport source (output valid, output row_index, output column_index, input ready);
  modport sink   (input valid, input row_index, input column_index, output ready);
endinterface

[src/csfv_out_if.sv]
// Result channel of the vertex generator: valid/ready plus one vertex.
// Depends on nothing.
`timescale 1ns / 1ps
interface csfv_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] vertex_x;
  logic signed [16:0] vertex_y;
  logic signed [16:0] vertex_z;
  logic               index_invalid;

  modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                  output index_invalid, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                  input index_invalid, output ready);
endinterface

[src/csfv_cordic.sv]
// Grid index to angle, then a fully pipelined rotation-mode CORDIC giving the
// gain-scaled cosine and signed sine in Q15. Depends on csfv_pkg.
`timescale 1ns / 1ps
module csfv_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [8:0]         idx,
  input  logic [3:0]         lvl,
  output logic signed [17:0] cos_o,
  output logic signed [17:0] sin_o
);
  localparam int STEPS = csfv_pkg::CORDIC_STEPS;
  localparam int W     = csfv_pkg::CORDIC_W;

  logic [12:0] n, k2, m;
  logic        neg;
  logic [42:0] prod, ang;

  always_comb begin
    n    = 13'd1 << lvl;
    k2   = {3'b000, idx, 1'b0};
    neg  = k2 < n;
    m    = neg ? (n - k2) : (k2 - n);
    prod = 43'(csfv_pkg::ATAN0) * 43'(m);
    ang  = prod >> lvl;
  end

  logic signed [W-1:0] x_r [0:STEPS];
  logic signed [W-1:0] y_r [0:STEPS];
  logic signed [W-1:0] z_r [0:STEPS-1];
  logic                neg_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= csfv_pkg::CORDIC_X0;
      y_r[0]   <= '0;
      z_r[0]   <= $signed({3'b000, ang[30:0]});
      neg_r[0] <= neg;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    logic signed [W-1:0] dx, dy, at;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = $signed(W'(csfv_pkg::atan_q30(i)));

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
        end
      end
    end

    if (i < STEPS - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[i+1] <= (!z_r[i][W-1]) ? (z_r[i] - at) : (z_r[i] + at);
        end
      end
    end
  end

  logic signed [W-1:0] xs, ys;
  logic signed [17:0]  ys18;
  assign xs    = x_r[STEPS] >>> 15;
  assign ys    = y_r[STEPS] >>> 15;
  assign ys18  = ys[17:0];
  assign cos_o = xs[17:0];
  assign sin_o = neg_r[STEPS] ? -ys18 : ys18;

endmodule

[src/csfv_isqrt.sv]
// Pipelined floor square root, two radicand bits per stage.
// Depends on csfv_pkg.
`timescale 1ns / 1ps
module csfv_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [37:0] val,
  output logic [18:0] root
);
  localparam int STEPS = csfv_pkg::SQRT_STEPS;

  logic [21:0] rem_r [1:STEPS-1];
  logic [18:0] q_r   [1:STEPS];
  logic [37:0] v_r   [1:STEPS-1];

  for (genvar j = 0; j < STEPS; j++) begin : g_st
    logic [21:0] rin, r2, t;
    logic [18:0] qin;
    logic [37:0] vin;
    logic        take;

    if (j == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign vin = val;
    end else begin : g_next
      assign rin = rem_r[j];
      assign qin = q_r[j];
      assign vin = v_r[j];
    end

    assign r2   = {rin[19:0], vin[37:36]};
    assign t    = {1'b0, qin, 2'b01};
    assign take = r2 >= t;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j+1] <= {qin[17:0], take};
      end
    end

    if (j < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= take ? (r2 - t) : r2;
          v_r[j+1]   <= vin << 2;
        end
      end
    end
  end

  assign root = q_r[STEPS];

endmodule

[src/csfv_div.sv]
// Pipelined restoring divider, one quotient bit per stage; the quotient is
// known to fit in DIV_STEPS bits. Depends on csfv_pkg.
`timescale 1ns / 1ps
module csfv_div (
  input  logic        clk,
  input  logic        en,
  input  logic [36:0] num,
  input  logic [19:0] den,
  output logic [16:0] quot
);
  localparam int STEPS = csfv_pkg::DIV_STEPS;

  logic [36:0] rem_r [1:STEPS-1];
  logic [19:0] den_r [1:STEPS-1];
  logic [16:0] q_r   [1:STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_st
    logic [36:0] rin, trial;
    logic [19:0] din;
    logic [16:0] qin;
    logic        take;

    if (j == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[j];
      assign din = den_r[j];
      assign qin = q_r[j];
    end

    assign trial = 37'(din) << (STEPS - 1 - j);
    assign take  = rin >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j+1] <= {qin[15:0], take};
      end
    end

    if (j < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= take ? (rin - trial) : rin;
          den_r[j+1] <= din;
        end
      end
    end
  end

  assign quot = q_r[STEPS];

endmodule

[src/cube_sphere_face_vertex.sv]
// Cube-sphere +X face vertex generator, top level.
// Throughput: one vertex per cycle; the whole pipeline holds while a result
// waits at the output, so nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and sets level 0 and
// radius 1.0. Depends on csfv_pkg, both channel interfaces and the submodules.
`timescale 1ns / 1ps
module cube_sphere_face_vertex #(
  parameter int MAX_SUBDIVISION      = 8,
  parameter int RADIUS_FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  csfv_in_if.sink     in_ch,
  csfv_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int T_P   = csfv_pkg::CORDIC_LAT + 1;
  localparam int T_NUM = T_P + 3 + csfv_pkg::SQRT_STEPS;
  localparam int LAT   = T_NUM + csfv_pkg::DIV_STEPS + 1;
  localparam int D1    = csfv_pkg::SQRT_STEPS + 2;
  localparam logic [3:0]  LVL_MAX   = 4'(MAX_SUBDIVISION);
  localparam logic [16:0] RAD_RESET = 17'(33'd1 << RADIUS_FRACTION_BITS);

  // Configuration registers
  logic [3:0]  level_r;
  logic [16:0] radius_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= 4'd0;
      radius_r <= RAD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        csfv_pkg::REG_LEVEL:  level_r  <= cfg_pwdata[3:0];
        csfv_pkg::REG_RADIUS: radius_r <= {1'b0, cfg_pwdata[15:0]};
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      csfv_pkg::REG_LEVEL:  cfg_prdata = 32'(level_r);
      csfv_pkg::REG_RADIUS: cfg_prdata = 32'(radius_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // Pipeline control
  csfv_pkg::csfv_side_t side_r [1:LAT];
  logic        en;
  logic [3:0]  lvl;
  logic [12:0] n;
  logic        bad_idx;

  assign en          = !side_r[LAT].valid || out_ch.ready;
  assign in_ch.ready = en;
  assign lvl         = (level_r > LVL_MAX) ? LVL_MAX : level_r;
  assign n           = 13'd1 << lvl;
  assign bad_idx     = (13'(in_ch.row_index) > n) || (13'(in_ch.column_index) > n);

  // Trigonometry of longitude (column) and latitude (row)
  logic signed [17:0] c1, s1, c2, s2raw;

  csfv_cordic u_lon (.clk(clk), .en(en), .idx(in_ch.column_index), .lvl(lvl),
                     .cos_o(c1), .sin_o(s1));
  csfv_cordic u_lat (.clk(clk), .en(en), .idx(in_ch.row_index), .lvl(lvl),
                     .cos_o(c2), .sin_o(s2raw));

  // Direction: d1 and d2 take a minus sign; d1 = -cos(lon)*sin(lat), d2 = -sin(lon)*cos(lat).
  logic signed [35:0] p0, p1, p2;
  logic signed [37:0] q0, q1, q2;
  assign p0 = c1 * c2;
  assign p1 = c1 * s2raw;
  assign p2 = s1 * c2;
  assign q0 = 38'(p0);
  assign q1 = -38'(p1);
  assign q2 = -38'(p2);

  logic [17:0] mag_dl [0:D1][0:2];
  logic [35:0] sq_r [0:2];
  logic [37:0] sum_r;
  logic [18:0] len;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_dl[0][0] <= csfv_pkg::abs_shr15(q0);
      mag_dl[0][1] <= csfv_pkg::abs_shr15(q1);
      mag_dl[0][2] <= csfv_pkg::abs_shr15(q2);
      for (int k = 1; k <= D1; k++) begin
        mag_dl[k] <= mag_dl[k-1];
      end
      for (int j = 0; j < 3; j++) begin
        sq_r[j] <= 36'(mag_dl[0][j]) * 36'(mag_dl[0][j]);
      end
      sum_r <= 38'(sq_r[0]) + 38'(sq_r[1]) + 38'(sq_r[2]);
    end
  end

  csfv_isqrt u_sqrt (.clk(clk), .en(en), .val(sum_r), .root(len));

  // Rounded scale: (2*|d|*radius + len) / (2*len)
  logic [36:0] num_r [0:2];
  logic [19:0] den_r;
  logic [16:0] quot [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        num_r[j] <= 37'({mag_dl[D1][j], 1'b0}) * 37'(radius_r) + 37'(len);
      end
      den_r <= {len, 1'b0};
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_div
    csfv_div u_div (.clk(clk), .en(en), .num(num_r[j]), .den(den_r), .quot(quot[j]));
  end

  // Side information travels stage by stage with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= LAT; k++) begin
        side_r[k] <= '0;
      end
    end else if (en) begin
      side_r[1] <= '{valid: in_ch.valid, bad: bad_idx, kill: bad_idx, neg: 3'b000};
      for (int k = 2; k <= LAT; k++) begin
        if (k == T_P) begin
          side_r[k] <= '{valid: side_r[k-1].valid, bad: side_r[k-1].bad,
                         kill: side_r[k-1].kill, neg: {q2[37], q1[37], q0[37]}};
        end else if (k == T_NUM) begin
          side_r[k] <= '{valid: side_r[k-1].valid, bad: side_r[k-1].bad,
                         kill: side_r[k-1].kill || (len == 19'd0),
                         neg: side_r[k-1].neg};
        end else begin
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  // Output stage: saturate, restore sign, zero a rejected item.
  logic signed [16:0] vtx_r [0:2];
  logic               inv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        logic [15:0]        sat;
        logic signed [16:0] mag;
        sat = (quot[j] > 17'd65535) ? 16'hFFFF : quot[j][15:0];
        mag = $signed({1'b0, sat});
        if (side_r[LAT-1].kill) begin
          vtx_r[j] <= '0;
        end else begin
          vtx_r[j] <= side_r[LAT-1].neg[j] ? -mag : mag;
        end
      end
      inv_r <= side_r[LAT-1].bad;
    end
  end

  assign out_ch.valid         = side_r[LAT].valid;
  assign out_ch.vertex_x      = vtx_r[0];
  assign out_ch.vertex_y      = vtx_r[1];
  assign out_ch.vertex_z      = vtx_r[2];
  assign out_ch.index_invalid = inv_r;

  // Checks
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> side_r[1].valid)
    else $error("accepted item did not enter the pipeline");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready does not follow the output stall");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.index_invalid) |->
      (out_ch.vertex_x == 0 && out_ch.vertex_y == 0 && out_ch.vertex_z == 0))
    else $error("rejected index gave nonzero coordinates");

  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !out_ch.vertex_x[16])
    else $error("vertex x is negative on the +X face");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (side_r[T_NUM].valid && !en) |=> (side_r[T_NUM].valid && $stable(num_r[0])))
    else $error("pipeline moved during a stall");

endmodule
